// File: rtl/rgb_led_bit_encoder_macros.svh
// ---------------------------------------------------------------------------
// rgb_led_bit_encoder_macros: assertion macros for the LED bit encoder
// Checks are clocked on clk and switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_BIT_ENCODER_MACROS_SVH
`define RGB_LED_BIT_ENCODER_MACROS_SVH

// same-cycle implication
`define RGBLED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBLED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rgbled_pkg.sv
// ---------------------------------------------------------------------------
// rgbled_pkg: shared types and constants of the RGB LED bit encoder
// Register map, reset values, field widths and the brightness tan table.
// ---------------------------------------------------------------------------
package rgbled_pkg;

  localparam int ChanW     = 8;
  localparam int DutyW     = 8;
  localparam int GapW      = 8;
  localparam int BrightW   = 6;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;
  localparam int TanW      = 17;   // unsigned 1.16
  localparam int BitsPerLed = 24;
  localparam int SlotCntW  = 5;

  localparam logic [BrightW-1:0] BRIGHT_RST = 6'd15;
  localparam logic [DutyW-1:0]   HIGH_RST   = 8'd60;
  localparam logic [DutyW-1:0]   LOW_RST    = 8'd30;
  localparam logic [GapW-1:0]    GAP_RST    = 8'd50;

  localparam logic [SlotCntW-1:0] LAST_BIT_SLOT = 5'd23;
  localparam logic [SlotCntW-1:0] GAP_SLOT      = 5'd24;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_HIGH_DUTY  = 2'd1,
    REG_LOW_DUTY   = 2'd2,
    REG_GAP_LENGTH = 2'd3
  } reg_idx_t;

  // round(tan(b deg) * 65536); angles above 45 saturate to a factor of one
  function automatic logic [TanW-1:0] tan_q16(input logic [BrightW-1:0] b);
    logic [TanW-1:0] t;
    case (b)
      6'd0:  t = 17'd0;     6'd1:  t = 17'd1144;  6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;  6'd4:  t = 17'd4583;  6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;  6'd7:  t = 17'd8047;  6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380; 6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
      6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
      6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
      6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
      6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
      6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
      6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
      6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
      6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
      6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
      6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
      6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/rgbled_intf.sv
// ---------------------------------------------------------------------------
// rgbled_intf: valid/ready channels of the RGB LED bit encoder
// LED color input, duty slot output and configuration write channel.
// ---------------------------------------------------------------------------
interface rgbled_in_if;
  logic                           valid;
  logic                           ready;
  logic [rgbled_pkg::ChanW-1:0]   green;
  logic [rgbled_pkg::ChanW-1:0]   red;
  logic [rgbled_pkg::ChanW-1:0]   blue;
  logic                           final_led;

  modport source (output valid, green, red, blue, final_led, input ready);
  modport sink   (input valid, green, red, blue, final_led, output ready);
endinterface

interface rgbled_out_if;
  logic                           valid;
  logic                           ready;
  logic [rgbled_pkg::DutyW-1:0]   duty;
  logic                           is_gap;
  logic [rgbled_pkg::GapW-1:0]    gap_slots;
  logic                           end_of_run;

  modport source (output valid, duty, is_gap, gap_slots, end_of_run, input ready);
  modport sink   (input valid, duty, is_gap, gap_slots, end_of_run, output ready);
endinterface

interface rgbled_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rgbled_pkg::CfgIdxW-1:0]  index;
  logic [rgbled_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rgb_led_bit_encoder.sv
// ---------------------------------------------------------------------------
// rgb_led_bit_encoder: serial RGB LED bit encoder
// Scales one LED color by tan(brightness) and sends 24 PWM duty slots.
// ---------------------------------------------------------------------------
// Usage:
//   led  : one item per LED (green, red, blue, final_led).
//   slot : one item per bit slot, MSB first, green then red then blue; a
//          one bit carries high_duty, a zero bit low_duty. After an LED
//          with final_led set, one more item marks the reset gap
//          (is_gap = 1, gap_slots = gap_length). end_of_run flags the
//          last item caused by each LED.
//   cfg  : register writes (brightness, high_duty, low_duty, gap_length),
//          always ready; write only while the encoder is idle.
// Path: the first slot of an LED goes through the table lookup stage,
//   the multiply stage and the serializer, each of them registered.
// Throughput: one slot per cycle while slot.ready is high, so 24 slots
//   per LED, 25 for the last LED of a frame; the serializer sets this
//   rate. Two more LEDs can sit in the front stages while it works.
// Reset: registers return to 15 / 60 / 30 / 50 and the pipeline empties.
// Stall: while slot.ready is low the current slot holds and the pipeline
//   fills up and then drops led.ready; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "rgb_led_bit_encoder_macros.svh"

module rgb_led_bit_encoder (
  input  logic            clk,
  input  logic            rst,
  rgbled_cfg_if.sink      cfg,
  rgbled_in_if.sink       led,
  rgbled_out_if.source    slot
);

  // configuration registers
  logic [rgbled_pkg::BrightW-1:0] brightness;
  logic [rgbled_pkg::DutyW-1:0]   high_duty;
  logic [rgbled_pkg::DutyW-1:0]   low_duty;
  logic [rgbled_pkg::GapW-1:0]    gap_length;

  // stage 1: captured color and tan factor
  logic                           s1_valid;
  logic                           s1_ready;
  logic [rgbled_pkg::ChanW-1:0]   s1_green;
  logic [rgbled_pkg::ChanW-1:0]   s1_red;
  logic [rgbled_pkg::ChanW-1:0]   s1_blue;
  logic                           s1_last;
  logic [rgbled_pkg::TanW-1:0]    s1_tan;

  // stage 2: scaled 24-bit word
  logic                           s2_valid;
  logic                           s2_ready;
  logic [rgbled_pkg::BitsPerLed-1:0] s2_word;
  logic                           s2_last;
  logic [24:0]                    prod_g;
  logic [24:0]                    prod_r;
  logic [24:0]                    prod_b;

  // stage 3: serializer
  logic                           s3_valid;
  logic [rgbled_pkg::BitsPerLed-1:0] s3_word;
  logic                           s3_last;
  logic [rgbled_pkg::SlotCntW-1:0] cnt;
  logic                           slot_take;
  logic                           slot_final;
  logic                           s3_load;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= rgbled_pkg::BRIGHT_RST;
      high_duty  <= rgbled_pkg::HIGH_RST;
      low_duty   <= rgbled_pkg::LOW_RST;
      gap_length <= rgbled_pkg::GAP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (rgbled_pkg::reg_idx_t'(cfg.index))
        rgbled_pkg::REG_BRIGHTNESS: brightness <= cfg.data[rgbled_pkg::BrightW-1:0];
        rgbled_pkg::REG_HIGH_DUTY:  high_duty  <= cfg.data;
        rgbled_pkg::REG_LOW_DUTY:   low_duty   <= cfg.data;
        rgbled_pkg::REG_GAP_LENGTH: gap_length <= cfg.data;
      endcase
    end
  end

  // stage 1: capture input, look up tan factor
  assign s1_ready  = !s1_valid || s2_ready;
  assign led.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= led.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && led.valid) begin
      s1_green <= led.green;
      s1_red   <= led.red;
      s1_blue  <= led.blue;
      s1_last  <= led.final_led;
      s1_tan   <= rgbled_pkg::tan_q16(brightness);
    end
  end

  // stage 2: scale each channel, floor(ch * tan / 65536)
  always_comb begin
    prod_g = 25'(s1_green) * 25'(s1_tan);
    prod_r = 25'(s1_red)   * 25'(s1_tan);
    prod_b = 25'(s1_blue)  * 25'(s1_tan);
  end

  assign s2_ready = !s2_valid || s3_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_word <= {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
      s2_last <= s1_last;
    end
  end

  // stage 3: shift out one slot per accepted output item
  assign slot_take  = slot.valid && slot.ready;
  assign slot_final = (cnt == rgbled_pkg::GAP_SLOT) ||
                      ((cnt == rgbled_pkg::LAST_BIT_SLOT) && !s3_last);
  assign s3_load    = !s3_valid || (slot_take && slot_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      cnt      <= '0;
    end else if (s3_load) begin
      s3_valid <= s2_valid;
      cnt      <= '0;
    end else if (slot_take) begin
      cnt      <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load && s2_valid) begin
      s3_word <= s2_word;
      s3_last <= s2_last;
    end else if (slot_take) begin
      s3_word <= {s3_word[rgbled_pkg::BitsPerLed-2:0], 1'b0};
    end
  end

  // output slot
  assign slot.valid      = s3_valid;
  assign slot.is_gap     = (cnt == rgbled_pkg::GAP_SLOT);
  assign slot.duty       = slot.is_gap ? '0 :
                           (s3_word[rgbled_pkg::BitsPerLed-1] ? high_duty : low_duty);
  assign slot.gap_slots  = slot.is_gap ? gap_length : '0;
  assign slot.end_of_run = slot_final;

  // checks
  `RGBLED_ASSERT_NOW(a_gap_only_last, s3_valid && slot.is_gap, s3_last, "gap on non-final LED")
  `RGBLED_ASSERT_NOW(a_cnt_range, s3_valid, cnt <= rgbled_pkg::GAP_SLOT, "slot counter out of range")
  `RGBLED_ASSERT_NEXT(a_run_restart, slot_take && slot_final, cnt == '0, "counter not cleared")
  `RGBLED_ASSERT_NEXT(a_s2_hold, s2_valid && !s2_ready, s2_valid, "scaled word dropped under stall")

endmodule
